// ----- hdl/cwq_pkg.sv -----
// Package for the circular wait queue: widths, operation and status codes,
// sequencer states, interface structs and the ring index helper.
// No dependencies.
package cwq_pkg;

   localparam int STORE_DEPTH  = 64;
   localparam int ADDR_W       = 6;
   localparam int CNT_W        = 7;
   localparam int PID_W        = 16;
   localparam int OP_W         = 3;
   localparam int DEF_CAPACITY = 64;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND        = 3'd0,
      OP_APPEND_ABSENT = 3'd1,
      OP_CONTAINS      = 3'd2,
      OP_REMOVE        = 3'd3,
      OP_POP           = 3'd4,
      OP_DRAIN         = 3'd5,
      OP_LIST          = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_WALK,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [PID_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      status_type       status;
      logic             found;
      logic [PID_W-1:0] pid;
      logic [CNT_W-1:0] total;
      logic             last;
   } rsp_type;

   // Physical slot of the entry at the given distance from the head.
   function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  offset,
                                                   input logic [CNT_W-1:0]  cap);
      logic [CNT_W:0] sum;
      sum = {2'b00, head} + {1'b0, offset};
      if (sum >= {1'b0, cap}) begin
         sum = sum - {1'b0, cap};
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ----- hdl/circular_wait_queue_unit.sv -----
// Append, pop, the unused code and every case that finds the queue empty are answered from the
// reply or walk state through the registered output, and the next request is taken once the
// sequencer is idle again. Contains, append if absent and remove walk the stored entries one per
// cycle; drain and list give one result per cycle while the output register is free to take it,
// the pace being set by the single read port of the entry store that the sequencer walks from the
// head. One request is handled at a time.
//
// Top level of the circular wait queue: output register and instances of
// cwq_ctrl and cwq_store. Depends on cwq_pkg.
module circular_wait_queue_unit
   import cwq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pid_value[15:0], max_count[22:16]
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_pid[15:0], entry_total[22:16]
   output logic [2:0]  rsp_tuser,  // status[1:0], found[2]
   output logic        rsp_tlast
);

   mem_req_type      mreq;
   logic [PID_W-1:0] rd_data;
   logic             out_free;
   logic             rsp_load;
   rsp_type          rsp_next;

   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   cwq_store u_store (
      .clock   (clock),
      .mreq    (mreq),
      .rd_data (rd_data)
   );

   cwq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .mreq       (mreq),
      .rd_data    (rd_data),
      .out_free   (out_free),
      .rsp_load   (rsp_load),
      .rsp_next   (rsp_next)
   );

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_load) begin
         out_valid_in = 1'b1;
         out_in       = rsp_next;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.total, out_ff.pid};
   assign rsp_tuser  = {out_ff.found, out_ff.status};
   assign rsp_tlast  = out_ff.last;

endmodule

// ----- hdl/cwq_store.sv -----
// Entry store of the circular wait queue: one write port and one read port
// with registered read data. Depends on cwq_pkg.
module cwq_store
   import cwq_pkg::*;
(
   input  logic             clock,
   input  mem_req_type      mreq,
   output logic [PID_W-1:0] rd_data
);

   logic [PID_W-1:0] store_ff [STORE_DEPTH];
   logic [PID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         store_ff[mreq.waddr] <= mreq.wdata;
      end
      rd_data_ff <= store_ff[mreq.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cwq_ctrl.sv -----
// Sequencer of the circular wait queue: head and count registers, the walk
// over stored entries with one shared compare, and result generation.
// Depends on cwq_pkg; drives cwq_store through a mem_req_type struct.
module cwq_ctrl
   import cwq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   input  logic [OP_W-1:0]  req_tuser,
   output mem_req_type      mreq,
   input  logic [PID_W-1:0] rd_data,
   input  logic             out_free,
   output logic             rsp_load,
   output rsp_type          rsp_next
);

   localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
   localparam logic [ADDR_W-1:0] HEAD_MAX = ADDR_W'(CAPACITY - 1);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [PID_W-1:0] pid_ff, pid_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             found_ff, found_in;

   logic [CNT_W-1:0] windex;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] list_n;
   logic [PID_W-1:0] req_pid;
   logic [CNT_W-1:0] req_max;
   logic             is_full;
   logic             last_entry;
   logic             walk_last;

   assign req_pid    = req_tdata[15:0];
   assign req_max    = req_tdata[22:16];
   assign count_m1   = count_ff - 7'd1;
   assign is_full    = count_ff >= CAP_C;
   assign last_entry = idx_ff == count_m1;
   assign walk_last  = idx_ff == (lim_ff - 7'd1);
   assign list_n     = (req_max < count_ff) ? req_max : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      pid_ff    <= pid_in;
      lim_ff    <= lim_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      pid_in     = pid_ff;
      lim_in     = lim_ff;
      idx_in     = idx_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      req_tready = 1'b0;
      windex     = count_ff;
      mreq.we    = 1'b0;
      mreq.wdata = pid_ff;
      rsp_load   = 1'b0;
      rsp_next.status = status_ff;
      rsp_next.found  = found_ff;
      rsp_next.pid    = '0;
      rsp_next.total  = count_ff;
      rsp_next.last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            idx_in     = '0;
            if (req_tvalid) begin
               op_in     = op_type'(req_tuser);
               pid_in    = req_pid;
               found_in  = 1'b0;
               status_in = ST_OK;
               state_in  = S_REPLY;
               unique case (op_type'(req_tuser))
                  OP_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        mreq.we    = 1'b1;
                        mreq.wdata = req_pid;
                        count_in   = count_ff + 7'd1;
                     end
                  end
                  OP_APPEND_ABSENT: begin
                     if (count_ff == '0) begin
                        mreq.we    = 1'b1;
                        mreq.wdata = req_pid;
                        count_in   = count_ff + 7'd1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_CONTAINS, OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        lim_in   = 7'd1;
                        state_in = S_WALK;
                     end
                  end
                  OP_DRAIN: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        head_in   = '0;
                     end else begin
                        lim_in   = count_ff;
                        state_in = S_WALK;
                     end
                  end
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (list_n != '0) begin
                        lim_in   = list_n;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (rd_data == pid_ff) begin
               found_in = 1'b1;
               state_in = S_REPLY;
               if (op_ff == OP_REMOVE) begin
                  if (last_entry) begin
                     count_in = count_m1;
                  end else begin
                     idx_in   = idx_ff + 7'd1;
                     state_in = S_SHIFT;
                  end
               end
            end else if (last_entry) begin
               state_in = S_REPLY;
               if (op_ff == OP_APPEND_ABSENT) begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     mreq.we  = 1'b1;
                     count_in = count_ff + 7'd1;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end else begin
               idx_in = idx_ff + 7'd1;
            end
         end

         S_SHIFT: begin
            mreq.we    = 1'b1;
            mreq.wdata = rd_data;
            windex     = idx_ff - 7'd1;
            if (last_entry) begin
               count_in = count_m1;
               state_in = S_REPLY;
            end else begin
               idx_in = idx_ff + 7'd1;
            end
         end

         S_WALK: begin
            rsp_next.status = ST_OK;
            rsp_next.found  = 1'b0;
            rsp_next.pid    = rd_data;
            rsp_next.last   = walk_last;
            if (op_ff == OP_POP) begin
               rsp_next.total = count_m1;
            end else if (op_ff == OP_DRAIN) begin
               rsp_next.total = '0;
            end
            if (out_free) begin
               rsp_load = 1'b1;
               if (walk_last) begin
                  state_in = S_IDLE;
                  if (op_ff == OP_POP) begin
                     head_in  = (head_ff == HEAD_MAX) ? '0 : head_ff + 6'd1;
                     count_in = count_m1;
                  end else if (op_ff == OP_DRAIN) begin
                     head_in  = '0;
                     count_in = '0;
                  end
               end else begin
                  idx_in = idx_ff + 7'd1;
               end
            end
         end

         S_REPLY: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      mreq.waddr = ring_slot(head_ff, windex, CAP_C);
      mreq.raddr = ring_slot(head_ff, idx_in, CAP_C);
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("Entry count exceeds the capacity.");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= HEAD_MAX)
      else $error("Head index outside the ring.");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (mreq.we && state_ff != S_SHIFT) |=> count_ff == $past(count_ff) + 7'd1)
      else $error("Store written by an append without the count growing.");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> (idx_ff < lim_ff && lim_ff <= count_ff))
      else $error("Walk index runs past its limit.");
`endif

endmodule

// ----- bench/circular_wait_queue_unit_test.sv -----
// Self-checking bench for circular_wait_queue_unit: a stimulus table, then random runs of
// requests checked against a queue model kept here, with random stalls on both streams.
// Depends on cwq_pkg and circular_wait_queue_unit.
`timescale 1ns / 100ps

module circular_wait_queue_unit_test;
   import cwq_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int QUEUE_DEPTH  = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 370;
   localparam int IDLE_PCT     = 33;
   localparam int HOLD_AT      = 180;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_FROM   = 260;
   localparam int QUIET_TO     = 340;
   localparam int LINGER       = 100;
   localparam int STALL_LIMIT  = 4000;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [PID_W-1:0] pid;
      logic [CNT_W-1:0] max_n;
      logic             typed;
      rsp_type          want;
   } request_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [PID_W-1:0] waiting_pids[$];
   rsp_type          queued_replies[$];
   logic [PID_W-1:0] pid_pool[8];
   request_type      directed_rows[24];
   int               items_sent   = 0;
   int               replies_seen = 0;
   int               errors       = 0;
   int               full_seen    = 0;
   int               empty_seen   = 0;
   int               missing_seen = 0;
   int               idle_cycles  = 0;
   bit               hold_done    = 1'b0;

   circular_wait_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit quiet_stretch();
      return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
   endfunction

   task automatic predict_replies(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                                  input logic [CNT_W-1:0] max_n);
      int      pos;
      int      n;
      rsp_type r;
      pos = -1;
      foreach (waiting_pids[i]) begin
         if (pos < 0 && waiting_pids[i] == pid) begin
            pos = i;
         end
      end
      r = '{status: ST_OK, found: 1'b0, pid: '0, total: '0, last: 1'b1};
      case (op)
         OP_APPEND, OP_APPEND_ABSENT: begin
            if (op == OP_APPEND_ABSENT && pos >= 0) begin
               r.found = 1'b1;
            end else if (waiting_pids.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               waiting_pids.push_back(pid);
            end
            r.total = CNT_W'(waiting_pids.size());
            queued_replies.push_back(r);
         end
         OP_CONTAINS, OP_REMOVE: begin
            if (pos < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.found = 1'b1;
               if (op == OP_REMOVE) begin
                  waiting_pids.delete(pos);
               end
            end
            r.total = CNT_W'(waiting_pids.size());
            queued_replies.push_back(r);
         end
         OP_POP: begin
            if (waiting_pids.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.pid = waiting_pids.pop_front();
            end
            r.total = CNT_W'(waiting_pids.size());
            queued_replies.push_back(r);
         end
         OP_DRAIN: begin
            if (waiting_pids.size() == 0) begin
               r.status = ST_EMPTY;
               queued_replies.push_back(r);
            end else begin
               n = waiting_pids.size();
               for (int k = 0; k < n; k++) begin
                  r.pid  = waiting_pids[k];
                  r.last = (k == n - 1);
                  queued_replies.push_back(r);
               end
               waiting_pids.delete();
            end
         end
         OP_LIST: begin
            n = (max_n < waiting_pids.size()) ? int'(max_n) : waiting_pids.size();
            r.total = CNT_W'(waiting_pids.size());
            if (waiting_pids.size() == 0) begin
               r.status = ST_EMPTY;
               queued_replies.push_back(r);
            end else if (n == 0) begin
               queued_replies.push_back(r);
            end else begin
               for (int k = 0; k < n; k++) begin
                  r.pid  = waiting_pids[k];
                  r.last = (k == n - 1);
                  queued_replies.push_back(r);
               end
            end
         end
         default: begin
            r.total = CNT_W'(waiting_pids.size());
            queued_replies.push_back(r);
         end
      endcase
   endtask

   // Entered and left at a falling edge; the valid stays high into the next request.
   task automatic send_request(input request_type rq);
      while (!quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.op;
      req_tdata  <= {1'b0, rq.max_n, rq.pid};
      do @(posedge clock); while (!req_tready);
      predict_replies(rq.op, rq.pid, rq.max_n);
      if (rq.typed) begin
         void'(queued_replies.pop_back());
         queued_replies.push_back(rq.want);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (queued_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (LINGER) @(negedge clock);
   endtask

   function automatic request_type random_request();
      request_type rq;
      int          w;
      rq = '0;
      w  = $urandom_range(0, 99);
      if (w < 25)      rq.op = OP_APPEND;
      else if (w < 40) rq.op = OP_APPEND_ABSENT;
      else if (w < 55) rq.op = OP_CONTAINS;
      else if (w < 70) rq.op = OP_REMOVE;
      else if (w < 82) rq.op = OP_POP;
      else if (w < 92) rq.op = OP_LIST;
      else if (w < 96) rq.op = OP_DRAIN;
      else             rq.op = OP_UNUSED;
      w = $urandom_range(0, 9);
      if (w < 3 && waiting_pids.size() > 0) begin
         rq.pid = waiting_pids[$urandom_range(0, waiting_pids.size() - 1)];
      end else if (w < 7) begin
         rq.pid = pid_pool[$urandom_range(0, 7)];
      end else begin
         rq.pid = PID_W'($urandom_range(0, 65535));
      end
      w = $urandom_range(0, 19);
      if (w < 14)      rq.max_n = CNT_W'($urandom_range(0, 8));
      else if (w < 17) rq.max_n = CNT_W'($urandom_range(9, 63));
      else if (w < 18) rq.max_n = CNT_W'(QUEUE_DEPTH);
      else             rq.max_n = CNT_W'($urandom_range(65, 127));
      return rq;
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         case (rsp_tuser[1:0])
            ST_FULL:      full_seen++;
            ST_EMPTY:     empty_seen++;
            ST_NOT_FOUND: missing_seen++;
            default: ;
         endcase
         if (queued_replies.size() == 0) begin
            $error("reply with none expected: status %0d, pid %h", rsp_tuser[1:0],
                   rsp_tdata[15:0]);
            errors++;
         end else begin
            want = queued_replies.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser[1:0]);
               errors++;
            end
            if (rsp_tuser[2] !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tuser[2]);
               errors++;
            end
            if (rsp_tdata[15:0] !== want.pid) begin
               $error("out_pid: expected %h, got %h", want.pid, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[22:16] !== want.total) begin
               $error("entry_total: expected %0d, got %0d", want.total, rsp_tdata[22:16]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Stream stalled for %0d cycles with %0d replies outstanding.",
                     idle_cycles, queued_replies.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      request_type rq;
      int          seq_index;
      int          random_items;
      int          extra;
      directed_rows = '{
         '{OP_POP,           16'h0000, 7'd0,   1'b1, '{ST_EMPTY,     1'b0, 16'h0, 7'd0, 1'b1}},
         '{OP_DRAIN,         16'h0000, 7'd0,   1'b1, '{ST_EMPTY,     1'b0, 16'h0, 7'd0, 1'b1}},
         '{OP_LIST,          16'h0000, 7'd64,  1'b1, '{ST_EMPTY,     1'b0, 16'h0, 7'd0, 1'b1}},
         '{OP_CONTAINS,      16'h1234, 7'd0,   1'b1, '{ST_NOT_FOUND, 1'b0, 16'h0, 7'd0, 1'b1}},
         '{OP_REMOVE,        16'hFFFF, 7'd0,   1'b1, '{ST_NOT_FOUND, 1'b0, 16'h0, 7'd0, 1'b1}},
         '{OP_APPEND,        16'h0000, 7'd0,   1'b1, '{ST_OK,        1'b0, 16'h0, 7'd1, 1'b1}},
         '{OP_APPEND,        16'hFFFF, 7'd0,   1'b1, '{ST_OK,        1'b0, 16'h0, 7'd2, 1'b1}},
         '{OP_APPEND_ABSENT, 16'hFFFF, 7'd0,   1'b1, '{ST_OK,        1'b1, 16'h0, 7'd2, 1'b1}},
         '{OP_APPEND_ABSENT, 16'hA5A5, 7'd0,   1'b1, '{ST_OK,        1'b0, 16'h0, 7'd3, 1'b1}},
         '{OP_APPEND,        16'h0000, 7'd0,   1'b1, '{ST_OK,        1'b0, 16'h0, 7'd4, 1'b1}},
         '{OP_CONTAINS,      16'h0000, 7'd0,   1'b1, '{ST_OK,        1'b1, 16'h0, 7'd4, 1'b1}},
         '{OP_LIST,          16'h0000, 7'd0,   1'b1, '{ST_OK,        1'b0, 16'h0, 7'd4, 1'b1}},
         '{OP_LIST,          16'h0000, 7'd127, 1'b0, '0},
         '{OP_LIST,          16'h0000, 7'd2,   1'b0, '0},
         '{OP_REMOVE,        16'h0000, 7'd0,   1'b1, '{ST_OK,        1'b1, 16'h0, 7'd3, 1'b1}},
         '{OP_LIST,          16'h0000, 7'd64,  1'b0, '0},
         '{OP_UNUSED,        16'h5A5A, 7'd127, 1'b1, '{ST_OK,        1'b0, 16'h0, 7'd3, 1'b1}},
         '{OP_POP,           16'h0000, 7'd0,   1'b0, '0},
         '{OP_APPEND,        16'h8001, 7'd0,   1'b0, '0},
         '{OP_DRAIN,         16'h0000, 7'd0,   1'b0, '0},
         '{OP_POP,           16'h0000, 7'd0,   1'b1, '{ST_EMPTY,     1'b0, 16'h0, 7'd0, 1'b1}},
         '{OP_APPEND_ABSENT, 16'h7FFE, 7'd85,  1'b1, '{ST_OK,        1'b0, 16'h0, 7'd1, 1'b1}},
         '{OP_POP,           16'h0000, 7'd0,   1'b1, '{ST_OK,     1'b0, 16'h7FFE, 7'd0, 1'b1}},
         '{OP_CONTAINS,      16'h7FFE, 7'd0,   1'b1, '{ST_NOT_FOUND, 1'b0, 16'h0, 7'd0, 1'b1}}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
      end
      wait_for_replies();

      seq_index    = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         foreach (pid_pool[p]) begin
            pid_pool[p] = PID_W'($urandom_range(0, 65535));
         end
         if (seq_index == 0 || $urandom_range(0, 7) == 0) begin
            // Fill the ring, then push past capacity a few times.
            extra = $urandom_range(1, 3);
            while (extra > 0) begin
               if (waiting_pids.size() >= QUEUE_DEPTH) begin
                  extra--;
               end
               rq       = '0;
               rq.op    = $urandom_range(0, 1) ? OP_APPEND : OP_APPEND_ABSENT;
               rq.pid   = PID_W'($urandom_range(0, 65535));
               rq.max_n = CNT_W'($urandom_range(0, 127));
               send_request(rq);
               random_items++;
            end
         end else begin
            repeat ($urandom_range(10, 24)) begin
               rq = random_request();
               send_request(rq);
               if (rq.op != OP_UNUSED) begin
                  random_items++;
               end
            end
         end
         if (seq_index == 6) begin
            wait_for_replies();
         end
         seq_index++;
      end
      wait_for_replies();

      $display("Sent %0d requests in %0d random runs, including ring fills and overflow;",
               items_sent, seq_index);
      $display("checked %0d replies: %0d full, %0d empty, %0d not found.",
               replies_seen, full_seen, empty_seen, missing_seen);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
